// ----- rtl/sthc_pkg.sv -----
// Package for the serial terminal handshake controller.
// Holds the item, result and per-channel state types and all codes.
// No dependencies.
`default_nettype none
package sthc_pkg;

    localparam int MAX_TRIES   = 20;
    localparam int MAX_PAYLOAD = 22;
    localparam int TRY_W       = $clog2(MAX_TRIES + 2);

    localparam logic [TRY_W-1:0] TRY_LIMIT = TRY_W'(MAX_TRIES);
    localparam logic [TRY_W-1:0] TRY_ONE   = TRY_W'(1);

    localparam logic [1:0] REQ_POLL    = 2'd0;
    localparam logic [1:0] REQ_TX      = 2'd1;
    localparam logic [1:0] REQ_RX      = 2'd2;
    localparam logic [1:0] REQ_RESTART = 2'd3;

    localparam logic [1:0] ERR_OK       = 2'd0;
    localparam logic [1:0] ERR_DISABLED = 2'd1;
    localparam logic [1:0] ERR_TX_BUSY  = 2'd2;
    localparam logic [1:0] ERR_NO_RX    = 2'd3;

    localparam logic [1:0] PH_INACTIVE = 2'd0;
    localparam logic [1:0] PH_INIT     = 2'd1;
    localparam logic [1:0] PH_RUN      = 2'd2;

    localparam logic [1:0] SUB_START   = 2'd0;
    localparam logic [1:0] SUB_WAIT    = 2'd1;
    localparam logic [1:0] SUB_TIMEOUT = 2'd2;
    localparam logic [1:0] SUB_DONE    = 2'd3;

    localparam logic [7:0] CTRL_TX_TOGGLE = 8'h01;
    localparam logic [7:0] CTRL_RX_TOGGLE = 8'h02;
    localparam logic [7:0] CTRL_INIT_REQ  = 8'h04;
    localparam logic [7:0] CTRL_CLEAR     = 8'h00;

    typedef struct packed {
        logic [1:0] req_type;
        logic       channel;
        logic [7:0] status_byte;
        logic [7:0] rx_length;
        logic [7:0] tx_length;
    } item_t;

    typedef struct packed {
        logic [7:0]       control;
        logic [7:0]       length;
        logic             tx_ready;
        logic             rx_signal;
        logic [1:0]       req_phase;
        logic [1:0]       cur_phase;
        logic [1:0]       sub_step;
        logic [TRY_W-1:0] try_count;
        logic             failed;
    } chan_t;

    typedef struct packed {
        logic [1:0] error_code;
        logic [7:0] control_byte;
        logic [7:0] length_byte;
        logic       tx_ready;
        logic       rx_signal;
        logic [7:0] byte_count;
        logic [1:0] link_phase;
        logic       init_failed;
    } result_t;

endpackage
`default_nettype wire

// ----- rtl/serial_terminal_handshake_ctrl.sv -----
// An accepted beat is processed from the input register and its result is registered in
// the output register. Throughput: one beat per cycle unless the master side stalls.
// Reset (aresetn low, synchronous) clears both channels, the enable mask and all valids.
// Top level of the serial terminal handshake controller; uses sthc_pkg and sthc_step.
`default_nettype none
module serial_terminal_handshake_ctrl (
    input  wire        aclk,
    input  wire        aresetn,
    input  wire        cfg_we,
    input  wire [1:0]  cfg_wdata,
    input  wire        s_tvalid,
    output logic       s_tready,
    input  wire [23:0] s_tdata,   // status_byte, rx_length, tx_length
    input  wire [2:0]  s_tuser,   // req_type, channel
    output logic       m_tvalid,
    input  wire        m_tready,
    output logic [31:0] m_tdata,  // control_byte, length_byte, tx_ready, rx_signal,
                                  // byte_count, link_phase, init_failed, zero pad
    output logic [1:0] m_tuser    // error_code
);

    logic              chan_enabled;
    logic [1:0]        enable_mask_reg;
    logic              in_valid_reg;
    sthc_pkg::item_t   in_reg;
    logic              out_valid_reg;
    sthc_pkg::result_t out_reg;
    sthc_pkg::chan_t   chan_reg [2];
    sthc_pkg::chan_t   chan_next;
    sthc_pkg::result_t result_next;
    logic              advance;
    logic              fire;

    assign advance      = !out_valid_reg || m_tready;
    assign fire         = in_valid_reg && advance;
    assign s_tready     = !in_valid_reg || advance;
    assign chan_enabled = enable_mask_reg[in_reg.channel];

    sthc_step u_step (
        .item      (in_reg),
        .enabled   (chan_enabled),
        .chan_cur  (chan_reg[in_reg.channel]),
        .chan_next (chan_next),
        .result    (result_next)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            enable_mask_reg <= 2'b00;
        end else if (cfg_we) begin
            enable_mask_reg <= cfg_wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_reg.req_type    <= s_tuser[1:0];
            in_reg.channel     <= s_tuser[2];
            in_reg.status_byte <= s_tdata[7:0];
            in_reg.rx_length   <= s_tdata[15:8];
            in_reg.tx_length   <= s_tdata[23:16];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < 2; i++) begin
                chan_reg[i] <= '0;
            end
        end else if (fire) begin
            chan_reg[in_reg.channel] <= chan_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (fire) begin
            out_reg <= result_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_reg.error_code;
    assign m_tdata  = {3'b000, out_reg.init_failed, out_reg.link_phase, out_reg.byte_count,
                       out_reg.rx_signal, out_reg.tx_ready, out_reg.length_byte,
                       out_reg.control_byte};

endmodule
`default_nettype wire

// ----- rtl/sthc_step.sv -----
// Combinational step of one channel: poll, transmit, receive and restart.
// Depends on sthc_pkg.
`default_nettype none
module sthc_step (
    input  wire sthc_pkg::item_t   item,
    input  wire                    enabled,
    input  wire sthc_pkg::chan_t   chan_cur,
    output sthc_pkg::chan_t        chan_next,
    output sthc_pkg::result_t      result
);

    always_comb begin
        sthc_pkg::chan_t c;
        logic [1:0]      err;
        logic [7:0]      count;
        logic [7:0]      st;

        c     = chan_cur;
        err   = sthc_pkg::ERR_OK;
        count = 8'd0;
        st    = item.status_byte;

        if (item.req_type == sthc_pkg::REQ_RESTART) begin
            c.req_phase = sthc_pkg::PH_INIT;
            c.cur_phase = sthc_pkg::PH_INACTIVE;
            c.sub_step  = sthc_pkg::SUB_START;
            c.try_count = '0;
            c.failed    = 1'b0;
        end else if (!enabled) begin
            err = sthc_pkg::ERR_DISABLED;
        end else if (item.req_type == sthc_pkg::REQ_POLL) begin
            c.tx_ready  = (st[0] == c.control[0]);
            c.rx_signal = (st[1] != c.control[1]);

            if (c.req_phase == sthc_pkg::PH_INIT && c.cur_phase == sthc_pkg::PH_INACTIVE) begin
                case (c.sub_step)
                    sthc_pkg::SUB_START: begin
                        c.control   = sthc_pkg::CTRL_INIT_REQ;
                        c.length    = 8'd0;
                        c.sub_step  = sthc_pkg::SUB_WAIT;
                        c.try_count = '0;
                    end
                    sthc_pkg::SUB_WAIT: begin
                        if (c.try_count != '1) begin
                            c.try_count = c.try_count + sthc_pkg::TRY_ONE;
                        end
                        if (st[2]) begin
                            c.sub_step = sthc_pkg::SUB_DONE;
                        end
                        if (c.try_count > sthc_pkg::TRY_LIMIT) begin
                            c.sub_step = sthc_pkg::SUB_TIMEOUT;
                        end
                    end
                    sthc_pkg::SUB_TIMEOUT: begin
                        c.control   = sthc_pkg::CTRL_CLEAR;
                        c.req_phase = sthc_pkg::PH_INACTIVE;
                        c.cur_phase = sthc_pkg::PH_INACTIVE;
                        c.sub_step  = sthc_pkg::SUB_START;
                        c.failed    = 1'b1;
                    end
                    default: begin
                        c.req_phase = sthc_pkg::PH_RUN;
                        c.cur_phase = sthc_pkg::PH_INIT;
                        c.sub_step  = sthc_pkg::SUB_START;
                        c.try_count = '0;
                    end
                endcase
            end

            if (c.req_phase == sthc_pkg::PH_RUN && c.cur_phase == sthc_pkg::PH_INIT) begin
                case (c.sub_step)
                    sthc_pkg::SUB_START: begin
                        c.control   = sthc_pkg::CTRL_CLEAR;
                        c.length    = 8'd0;
                        c.sub_step  = sthc_pkg::SUB_WAIT;
                        c.try_count = '0;
                    end
                    sthc_pkg::SUB_WAIT: begin
                        if (c.try_count != '1) begin
                            c.try_count = c.try_count + sthc_pkg::TRY_ONE;
                        end
                        if (!st[2]) begin
                            c.sub_step = sthc_pkg::SUB_DONE;
                        end
                        if (c.try_count > sthc_pkg::TRY_LIMIT) begin
                            c.sub_step = sthc_pkg::SUB_TIMEOUT;
                        end
                    end
                    sthc_pkg::SUB_TIMEOUT: begin
                        c.req_phase = sthc_pkg::PH_INIT;
                        c.cur_phase = sthc_pkg::PH_INACTIVE;
                        c.sub_step  = sthc_pkg::SUB_START;
                        c.try_count = '0;
                    end
                    default: begin
                        c.req_phase = sthc_pkg::PH_RUN;
                        c.cur_phase = sthc_pkg::PH_RUN;
                        c.sub_step  = sthc_pkg::SUB_START;
                        c.try_count = '0;
                    end
                endcase
            end
        end else if (item.req_type == sthc_pkg::REQ_TX) begin
            if (!c.tx_ready) begin
                err = sthc_pkg::ERR_TX_BUSY;
            end else begin
                count      = (item.tx_length > 8'(sthc_pkg::MAX_PAYLOAD)) ?
                             8'(sthc_pkg::MAX_PAYLOAD) : item.tx_length;
                c.control  = c.control ^ sthc_pkg::CTRL_TX_TOGGLE;
                c.length   = count;
                c.tx_ready = 1'b0;
            end
        end else begin
            if (!c.rx_signal) begin
                err = sthc_pkg::ERR_NO_RX;
            end else begin
                count       = (item.rx_length > 8'(sthc_pkg::MAX_PAYLOAD)) ?
                              8'(sthc_pkg::MAX_PAYLOAD) : item.rx_length;
                c.control   = c.control ^ sthc_pkg::CTRL_RX_TOGGLE;
                c.rx_signal = 1'b0;
            end
        end

        chan_next           = c;
        result.error_code   = err;
        result.control_byte = c.control;
        result.length_byte  = c.length;
        result.tx_ready     = c.tx_ready;
        result.rx_signal    = c.rx_signal;
        result.byte_count   = count;
        result.link_phase   = c.cur_phase;
        result.init_failed  = c.failed;
    end

endmodule
`default_nettype wire

// ----- rtl/sthc_checker.sv -----
// Port-level checker for the serial terminal handshake controller, with its bind.
// Depends on sthc_pkg and the top-level port list.
`default_nettype none
module sthc_checker (
    input wire        aclk,
    input wire        aresetn,
    input wire        m_tvalid,
    input wire        m_tready,
    input wire [31:0] m_tdata,
    input wire [1:0]  m_tuser
);

    a_reset_clears_valid: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("Result valid seen right after reset.");

    a_stall_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("Stalled result beat changed.");

    a_error_no_count: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser != sthc_pkg::ERR_OK |-> m_tdata[25:18] == 8'd0)
        else $error("Rejected beat reports a byte count.");

    a_count_clamped: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[25:18] <= 8'(sthc_pkg::MAX_PAYLOAD))
        else $error("Byte count above payload limit.");

    a_phase_legal: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[27:26] <= sthc_pkg::PH_RUN)
        else $error("Illegal link phase code.");

endmodule

bind serial_terminal_handshake_ctrl sthc_checker u_sthc_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
`default_nettype wire

// ----- tb/serial_terminal_handshake_ctrl_tb.sv -----
// Self-checking testbench for the serial terminal handshake controller.
// It predicts every result beat from its own per-channel model and compares it field by field.
// Depends on sthc_pkg and on the serial_terminal_handshake_ctrl RTL.
module serial_terminal_handshake_ctrl_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import sthc_pkg::*;

    typedef struct {
        logic [7:0] ctrl;
        logic [7:0] len;
        bit         txr;
        bit         rxs;
        logic [1:0] req_ph;
        logic [1:0] cur_ph;
        logic [1:0] sub;
        int         tries;
        bit         failed;
    } term_chan_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        cfg_we = 1'b0;
    logic [1:0]  cfg_wdata = 2'b00;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [23:0] s_tdata = 24'h0;
    logic [2:0]  s_tuser = 3'b000;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;
    logic [1:0]  m_tuser;

    term_chan_t  chan_st[2];
    logic [1:0]  mask_model = 2'b00;
    result_t     pending_results[$];
    int          mismatches = 0;
    int          beats_sent = 0;
    int          stall_left = 0;
    bit          quiet = 1'b0;

    serial_terminal_handshake_ctrl dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    function automatic logic [7:0] clamp_payload(input logic [7:0] n);
        return (n > 8'(MAX_PAYLOAD)) ? 8'(MAX_PAYLOAD) : n;
    endfunction

    function automatic result_t step_terminal(input item_t it);
        term_chan_t c;
        result_t    r;
        logic [7:0] st;
        c = chan_st[it.channel];
        st = it.status_byte;
        r = '0;
        r.error_code = ERR_OK;
        if (it.req_type == REQ_RESTART) begin
            c.req_ph = PH_INIT;
            c.cur_ph = PH_INACTIVE;
            c.sub = SUB_START;
            c.tries = 0;
            c.failed = 1'b0;
        end else if (!mask_model[it.channel]) begin
            r.error_code = ERR_DISABLED;
        end else if (it.req_type == REQ_POLL) begin
            c.txr = (st[0] == c.ctrl[0]);
            c.rxs = (st[1] != c.ctrl[1]);
            if (c.req_ph == PH_INIT && c.cur_ph == PH_INACTIVE) begin
                case (c.sub)
                    SUB_START: begin
                        c.ctrl = CTRL_INIT_REQ;
                        c.len = 8'h00;
                        c.sub = SUB_WAIT;
                        c.tries = 0;
                    end
                    SUB_WAIT: begin
                        c.tries++;
                        if (st[2])
                            c.sub = SUB_DONE;
                        if (c.tries > MAX_TRIES)
                            c.sub = SUB_TIMEOUT;
                    end
                    SUB_TIMEOUT: begin
                        c.ctrl = CTRL_CLEAR;
                        c.req_ph = PH_INACTIVE;
                        c.cur_ph = PH_INACTIVE;
                        c.sub = SUB_START;
                        c.failed = 1'b1;
                    end
                    default: begin
                        c.req_ph = PH_RUN;
                        c.cur_ph = PH_INIT;
                        c.sub = SUB_START;
                        c.tries = 0;
                    end
                endcase
            end
            if (c.req_ph == PH_RUN && c.cur_ph == PH_INIT) begin
                case (c.sub)
                    SUB_START: begin
                        c.ctrl = CTRL_CLEAR;
                        c.len = 8'h00;
                        c.sub = SUB_WAIT;
                        c.tries = 0;
                    end
                    SUB_WAIT: begin
                        c.tries++;
                        if (!st[2])
                            c.sub = SUB_DONE;
                        if (c.tries > MAX_TRIES)
                            c.sub = SUB_TIMEOUT;
                    end
                    SUB_TIMEOUT: begin
                        c.req_ph = PH_INIT;
                        c.cur_ph = PH_INACTIVE;
                        c.sub = SUB_START;
                        c.tries = 0;
                    end
                    default: begin
                        c.req_ph = PH_RUN;
                        c.cur_ph = PH_RUN;
                        c.sub = SUB_START;
                        c.tries = 0;
                    end
                endcase
            end
        end else if (it.req_type == REQ_TX) begin
            if (!c.txr) begin
                r.error_code = ERR_TX_BUSY;
            end else begin
                r.byte_count = clamp_payload(it.tx_length);
                c.ctrl ^= CTRL_TX_TOGGLE;
                c.len = r.byte_count;
                c.txr = 1'b0;
            end
        end else begin
            if (!c.rxs) begin
                r.error_code = ERR_NO_RX;
            end else begin
                r.byte_count = clamp_payload(it.rx_length);
                c.ctrl ^= CTRL_RX_TOGGLE;
                c.rxs = 1'b0;
            end
        end
        chan_st[it.channel] = c;
        r.control_byte = c.ctrl;
        r.length_byte = c.len;
        r.tx_ready = c.txr;
        r.rx_signal = c.rxs;
        r.link_phase = c.cur_ph;
        r.init_failed = c.failed;
        return r;
    endfunction

    function automatic item_t make_item(input logic [1:0] req, input bit ch,
                                        input logic [7:0] st, input logic [7:0] rxl,
                                        input logic [7:0] txl);
        item_t it;
        it.req_type = req;
        it.channel = ch;
        it.status_byte = st;
        it.rx_length = rxl;
        it.tx_length = txl;
        return it;
    endfunction

    function automatic logic [7:0] rand_length();
        return ($urandom_range(0, 1) == 0) ? 8'($urandom_range(0, 255))
                                           : 8'($urandom_range(0, MAX_PAYLOAD + 2));
    endfunction

    task automatic send_beat(input item_t it);
        int gap;
        gap = quiet ? 0 : $urandom_range(0, 5);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {it.tx_length, it.rx_length, it.status_byte};
        s_tuser <= {it.channel, it.req_type};
        do @(posedge aclk); while (!s_tready);
        pending_results.push_back(step_terminal(it));
        beats_sent++;
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (3) @(posedge aclk);
    endtask

    task automatic write_mask(input logic [1:0] value);
        wait_drained();
        cfg_we <= 1'b1;
        cfg_wdata <= value;
        @(posedge aclk);
        cfg_we <= 1'b0;
        mask_model = value;
    endtask

    task automatic send_noise(input int n);
        repeat (n) send_beat(make_item(2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)),
                                       8'($urandom), 8'($urandom), 8'($urandom)));
    endtask

    task automatic test_disabled_channels();
        write_mask(2'b00);
        send_beat(make_item(REQ_POLL, 1'b0, 8'hFF, 8'h00, 8'h00));
        send_beat(make_item(REQ_TX, 1'b1, 8'h00, 8'h00, 8'hFF));
        send_beat(make_item(REQ_RX, 1'b0, 8'h00, 8'hFF, 8'h00));
        send_beat(make_item(REQ_RESTART, 1'b1, 8'h00, 8'h00, 8'h00));
        send_beat(make_item(REQ_POLL, 1'b1, 8'h04, 8'h00, 8'h00));
    endtask

    task automatic test_init_handshake();
        write_mask(2'b11);
        send_beat(make_item(REQ_RESTART, 1'b0, 8'h00, 8'h00, 8'h00));
        send_beat(make_item(REQ_POLL, 1'b0, 8'h00, 8'h00, 8'h00));
        send_beat(make_item(REQ_POLL, 1'b0, 8'h04, 8'h00, 8'h00));
        send_beat(make_item(REQ_POLL, 1'b0, 8'h04, 8'h00, 8'h00));
        send_beat(make_item(REQ_POLL, 1'b0, 8'h00, 8'h00, 8'h00));
        send_beat(make_item(REQ_POLL, 1'b0, 8'h00, 8'h00, 8'h00));
    endtask

    task automatic test_transfers();
        send_beat(make_item(REQ_POLL, 1'b0, 8'hFE, 8'h00, 8'h00));
        send_beat(make_item(REQ_TX, 1'b0, 8'h00, 8'h00, 8'hFF));
        send_beat(make_item(REQ_TX, 1'b0, 8'h00, 8'h00, 8'h05));
        send_beat(make_item(REQ_RX, 1'b0, 8'h00, 8'hC8, 8'h00));
        send_beat(make_item(REQ_RX, 1'b0, 8'h00, 8'h03, 8'h00));
        send_beat(make_item(REQ_POLL, 1'b0, 8'h01, 8'h00, 8'h00));
        send_beat(make_item(REQ_TX, 1'b0, 8'hFF, 8'h00, 8'(MAX_PAYLOAD)));
        send_beat(make_item(REQ_RX, 1'b0, 8'hFF, 8'(MAX_PAYLOAD + 1), 8'h00));
        send_beat(make_item(REQ_POLL, 1'b0, 8'h02, 8'h00, 8'h00));
        send_beat(make_item(REQ_TX, 1'b0, 8'h00, 8'h00, 8'h00));
        write_mask(2'b01);
        send_beat(make_item(REQ_TX, 1'b1, 8'h00, 8'h00, 8'h10));
    endtask

    task automatic run_link_session(input bit ch);
        int         acc_delay;
        int         rel_delay;
        int         i;
        int         n;
        int         pick;
        logic [7:0] st;
        logic [1:0] req;
        acc_delay = ($urandom_range(0, 3) == 0) ? MAX_TRIES : $urandom_range(0, MAX_TRIES + 2);
        rel_delay = ($urandom_range(0, 3) == 0) ? MAX_TRIES : $urandom_range(0, MAX_TRIES + 2);
        send_beat(make_item(REQ_RESTART, ch, 8'($urandom), 8'($urandom), 8'($urandom)));
        for (i = 0; i < 60 && mask_model[ch] && chan_st[ch].cur_ph != PH_RUN
                 && !chan_st[ch].failed; i++) begin
            st = 8'($urandom);
            if (chan_st[ch].sub == SUB_WAIT && chan_st[ch].req_ph == PH_INIT)
                st[2] = (chan_st[ch].tries >= acc_delay);
            else if (chan_st[ch].sub == SUB_WAIT && chan_st[ch].req_ph == PH_RUN)
                st[2] = (chan_st[ch].tries < rel_delay);
            pick = $urandom_range(0, 9);
            if (pick == 0)
                send_beat(make_item(2'($urandom_range(1, 2)), ch, st, rand_length(),
                                    rand_length()));
            else if (pick == 1)
                send_noise(1);
            else
                send_beat(make_item(REQ_POLL, ch, st, rand_length(), rand_length()));
        end
        n = $urandom_range(4, 16);
        repeat (n) begin
            st = 8'($urandom);
            st[0] = ($urandom_range(0, 3) != 0) ? chan_st[ch].ctrl[0] : ~chan_st[ch].ctrl[0];
            st[1] = ($urandom_range(0, 1) != 0) ? ~chan_st[ch].ctrl[1] : chan_st[ch].ctrl[1];
            st[2] = ($urandom_range(0, 5) == 0);
            pick = $urandom_range(0, 19);
            if (pick == 0)
                req = REQ_RESTART;
            else if (pick < 10)
                req = REQ_POLL;
            else if (pick < 15)
                req = REQ_TX;
            else
                req = REQ_RX;
            send_beat(make_item(req, ch, st, rand_length(), rand_length()));
        end
    endtask

    task automatic test_random_sessions();
        write_mask(2'b11);
        while (beats_sent < 700) begin
            quiet = ($urandom_range(0, 4) == 0);
            case ($urandom_range(0, 9))
                0: write_mask(($urandom_range(0, 3) == 0) ? 2'($urandom_range(0, 2)) : 2'b11);
                1: send_noise($urandom_range(1, 6));
                2: wait_drained();
                default: run_link_session(1'($urandom_range(0, 1)));
            endcase
        end
        quiet = 1'b0;
    endtask

    always @(posedge aclk) begin
        if (m_tvalid && m_tready)
            stall_left = quiet ? 0 : $urandom_range(0, 5);
        else if (stall_left > 0)
            stall_left--;
        m_tready <= (stall_left == 0);
    end

    task automatic compare_field(input string name, input logic [31:0] want,
                                 input logic [31:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch: expected %0d, got %0d", $time, name, want, got);
            mismatches++;
        end
    endtask

    always @(posedge aclk) begin
        result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected result beat: expected none, got %h/%h",
                         $time, m_tuser, m_tdata);
                mismatches++;
            end else begin
                want = pending_results.pop_front();
                compare_field("error_code", 32'(want.error_code), 32'(m_tuser));
                compare_field("control_byte", 32'(want.control_byte), 32'(m_tdata[7:0]));
                compare_field("length_byte", 32'(want.length_byte), 32'(m_tdata[15:8]));
                compare_field("tx_ready", 32'(want.tx_ready), 32'(m_tdata[16]));
                compare_field("rx_signal", 32'(want.rx_signal), 32'(m_tdata[17]));
                compare_field("byte_count", 32'(want.byte_count), 32'(m_tdata[25:18]));
                compare_field("link_phase", 32'(want.link_phase), 32'(m_tdata[27:26]));
                compare_field("init_failed", 32'(want.init_failed), 32'(m_tdata[28]));
                compare_field("pad", 32'd0, 32'(m_tdata[31:29]));
            end
        end
    end

    initial begin
        chan_st[0] = '{default: 0};
        chan_st[1] = '{default: 0};
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_disabled_channels();
        test_init_handshake();
        test_transfers();
        test_random_sessions();
        wait_drained();
        repeat (5) @(posedge aclk);
        if (mismatches == 0 && pending_results.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

    initial begin
        #5ms;
        $display("Timeout with %0d results outstanding", pending_results.size());
        $display("*** FAILED ***");
        $finish;
    end

endmodule
